// ===== src/fpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_pkg: shared types and constants for the position text parser
// Parse phases, character codes, the parser state record and the result record.
// ----------------------------------------------------------------------------
package fpp_pkg;

	localparam int BYTE_W    = 8;
	localparam int PHASE_W   = 4;
	localparam int SQ_W      = 6;
	localparam int COUNT_W   = 7;
	localparam int PIECE_W   = 3;
	localparam int RIGHTS_W  = 4;
	localparam int MOVES_W   = 16;
	localparam int DIGCNT_W  = 2;

	// Board size checks
	localparam logic [COUNT_W-1:0] BOARD_SQUARES = 7'd64;
	localparam logic [COUNT_W-1:0] RANK_COLUMNS  = 7'd8;

	// Parse phases
	localparam logic [PHASE_W-1:0] PH_BOARD   = 4'd0;
	localparam logic [PHASE_W-1:0] PH_SP1     = 4'd1;
	localparam logic [PHASE_W-1:0] PH_SIDE    = 4'd2;
	localparam logic [PHASE_W-1:0] PH_SP2     = 4'd3;
	localparam logic [PHASE_W-1:0] PH_CASTLE0 = 4'd4;
	localparam logic [PHASE_W-1:0] PH_CASTLE  = 4'd5;
	localparam logic [PHASE_W-1:0] PH_SP3     = 4'd6;
	localparam logic [PHASE_W-1:0] PH_EPFILE  = 4'd7;
	localparam logic [PHASE_W-1:0] PH_EPRANK  = 4'd8;
	localparam logic [PHASE_W-1:0] PH_SP4     = 4'd9;
	localparam logic [PHASE_W-1:0] PH_HALF    = 4'd10;
	localparam logic [PHASE_W-1:0] PH_FULL    = 4'd11;

	// Result kinds and status codes
	localparam logic KIND_PIECE   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_BAD   = 1'b1;

	// Character codes
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
	localparam logic [BYTE_W-1:0] CH_1     = 8'h31;
	localparam logic [BYTE_W-1:0] CH_8     = 8'h38;
	localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
	localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5A;
	localparam logic [BYTE_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LO_H  = 8'h68;
	localparam logic [BYTE_W-1:0] CH_LO_Z  = 8'h7A;
	localparam logic [BYTE_W-1:0] CH_W     = 8'h77;
	localparam logic [BYTE_W-1:0] CH_B     = 8'h62;
	localparam logic [BYTE_W-1:0] CH_P     = 8'h70;
	localparam logic [BYTE_W-1:0] CH_R     = 8'h72;
	localparam logic [BYTE_W-1:0] CH_N     = 8'h6E;
	localparam logic [BYTE_W-1:0] CH_Q     = 8'h71;
	localparam logic [BYTE_W-1:0] CH_K     = 8'h6B;
	localparam logic [BYTE_W-1:0] CH_UP_K  = 8'h4B;
	localparam logic [BYTE_W-1:0] CH_UP_Q  = 8'h51;
	localparam logic [BYTE_W-1:0] CASE_OFS = 8'h20;

	typedef struct packed {
		logic [PHASE_W-1:0]  phase;
		logic [COUNT_W-1:0]  square_count;
		logic [COUNT_W-1:0]  rank_fill;
		logic [RIGHTS_W-1:0] rights;
		logic                black_to_move;
		logic                ep_flag;
		logic [SQ_W-1:0]     ep_where;
		logic [MOVES_W-1:0]  half_count;
		logic [MOVES_W-1:0]  full_count;
		logic [DIGCNT_W-1:0] digit_count;
		logic                lead_zero;
		logic                finished;
	} fpp_state_t;

	typedef struct packed {
		logic                kind;
		logic [SQ_W-1:0]     square;
		logic [PIECE_W-1:0]  piece_type;
		logic                piece_black;
		logic                status;
		logic                active_black;
		logic [RIGHTS_W-1:0] castle_rights;
		logic                ep_valid;
		logic [SQ_W-1:0]     ep_square;
		logic [MOVES_W-1:0]  halfmoves;
		logic [MOVES_W-1:0]  fullmoves;
	} fpp_result_t;

	localparam fpp_state_t STATE_RESET = '{
		phase:         PH_BOARD,
		square_count:  '0,
		rank_fill:     '0,
		rights:        '0,
		black_to_move: 1'b0,
		ep_flag:       1'b0,
		ep_where:      '0,
		half_count:    '0,
		full_count:    '0,
		digit_count:   '0,
		lead_zero:     1'b0,
		finished:      1'b0
	};

endpackage

// ===== src/fen_position_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fen_position_parser: chess position text parser, one character per transfer
// Usage:
//  - Input channel (in_valid / in_stall): one text byte per transfer, with
//    first set on the opening byte of a new string to clear all parse state.
//  - Output channel (out_valid / out_stall): a placement result for each
//    piece letter, then one summary when the full-move field ends or at the
//    first malformed byte. After a summary the parser drops bytes until a
//    transfer with first set.
//  - Path: a result passes through the input register, then the result
//    register, after its input transfer. Throughput: one byte per cycle
//    while out_stall is low; the whole step is a single pass of logic
//    between the two registers.
//  - Stall: while out_stall holds a waiting result, the input register holds
//    its byte and in_stall rises once that register is full.
//  - Reset: arst_n clears the parse state to the board placement phase and
//    empties both registers. No clearing pass is needed.
// ----------------------------------------------------------------------------
module fen_position_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [fpp_pkg::BYTE_W-1:0]     byte_req,
	input  logic                           first,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           kind,
	output logic [fpp_pkg::SQ_W-1:0]       square,
	output logic [fpp_pkg::PIECE_W-1:0]    piece_type,
	output logic                           piece_black,
	output logic                           status,
	output logic                           active_black,
	output logic [fpp_pkg::RIGHTS_W-1:0]   castle_rights,
	output logic                           ep_valid,
	output logic [fpp_pkg::SQ_W-1:0]       ep_square,
	output logic [fpp_pkg::MOVES_W-1:0]    halfmoves,
	output logic [fpp_pkg::MOVES_W-1:0]    fullmoves
);

	// Input register
	logic                        valid_s1;
	logic [fpp_pkg::BYTE_W-1:0]  byte_s1;
	logic                        first_s1;

	// Parse state and result register
	fpp_pkg::fpp_state_t         state_q;
	fpp_pkg::fpp_state_t         state_nxt;
	logic                        emit;
	fpp_pkg::fpp_result_t        res;
	logic                        valid_s2;
	fpp_pkg::fpp_result_t        res_s2;

	logic                        in_xfer;
	logic                        advance;
	logic                        step;

	// The byte in the input register may be parsed whenever the result
	// register is empty or is being drained this cycle.
	assign advance  = !valid_s2 || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the payload on every input transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1  <= byte_req;
			first_s1 <= first;
		end
	end

	fpp_step u_step (
		.state_cur (state_q),
		.byte_in   (byte_s1),
		.first_in  (first_s1),
		.state_nxt (state_nxt),
		.emit      (emit),
		.res       (res)
	);

	// Advance the parse state once per parsed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpp_pkg::STATE_RESET;
		end else if (step) begin
			state_q <= state_nxt;
		end
	end

	// Result register: load on a producing step, drop after an output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= emit;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign kind          = res_s2.kind;
	assign square        = res_s2.square;
	assign piece_type    = res_s2.piece_type;
	assign piece_black   = res_s2.piece_black;
	assign status        = res_s2.status;
	assign active_black  = res_s2.active_black;
	assign castle_rights = res_s2.castle_rights;
	assign ep_valid      = res_s2.ep_valid;
	assign ep_square     = res_s2.ep_square;
	assign halfmoves     = res_s2.halfmoves;
	assign fullmoves     = res_s2.fullmoves;

	// A placement result carries no summary information
	a_piece_clean : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == fpp_pkg::KIND_PIECE) |->
			(status == fpp_pkg::STATUS_OK && halfmoves == '0 && fullmoves == '0 &&
			 castle_rights == '0 && !ep_valid))
		else $error("placement result with summary fields set");

	// An accepted text always ends with a full-move number of at least one
	a_full_nonzero : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == fpp_pkg::KIND_SUMMARY && status == fpp_pkg::STATUS_OK) |->
			(fullmoves != '0))
		else $error("accepted summary with zero full-move number");

	// Once finished, bytes without first produce nothing
	a_idle_quiet : assert property (@(posedge clk) disable iff (!arst_n)
		(step && state_q.finished && !first_s1) |-> !emit)
		else $error("result produced after summary");

	// A summary always leaves the parser finished
	a_summary_ends : assert property (@(posedge clk) disable iff (!arst_n)
		(step && emit && res.kind == fpp_pkg::KIND_SUMMARY) |=> state_q.finished)
		else $error("parser not finished after summary");

endmodule

// ===== src/fpp_digit_acc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_digit_acc: decimal counter digit accumulator
// Multiply by ten, add one digit, saturate at the counter maximum, and flag a
// digit that follows a leading zero.
// ----------------------------------------------------------------------------
module fpp_digit_acc (
	input  logic [fpp_pkg::MOVES_W-1:0]  acc,
	input  logic [3:0]                   digit,
	input  logic [fpp_pkg::DIGCNT_W-1:0] digit_count,
	input  logic                         lead_zero,
	output logic [fpp_pkg::MOVES_W-1:0]  acc_nxt,
	output logic [fpp_pkg::DIGCNT_W-1:0] digit_count_nxt,
	output logic                         lead_zero_nxt,
	output logic                         fault
);

	localparam int SUM_W = fpp_pkg::MOVES_W + 4;

	logic [SUM_W-1:0] acc_w;
	logic [SUM_W-1:0] sum;

	always_comb begin
		acc_w = SUM_W'(acc);
		// ten times the value as eight plus two
		sum   = (acc_w << 3) + (acc_w << 1) + SUM_W'(digit);
		fault = (digit_count != '0) && lead_zero;
		lead_zero_nxt = lead_zero | ((digit_count == '0) && (digit == 4'd0));
		digit_count_nxt = (digit_count < 2'd2) ? digit_count + 2'd1 : digit_count;
		if (sum[SUM_W-1:fpp_pkg::MOVES_W] != '0) begin
			acc_nxt = '1;
		end else begin
			acc_nxt = sum[fpp_pkg::MOVES_W-1:0];
		end
	end

endmodule

// ===== src/fpp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_step: one-character parse step
// Next parser state and the optional result for one registered character.
// ----------------------------------------------------------------------------
module fpp_step (
	input  fpp_pkg::fpp_state_t           state_cur,
	input  logic [fpp_pkg::BYTE_W-1:0]    byte_in,
	input  logic                          first_in,
	output fpp_pkg::fpp_state_t           state_nxt,
	output logic                          emit,
	output fpp_pkg::fpp_result_t          res
);

	// {known, code}
	function automatic logic [fpp_pkg::PIECE_W:0] piece_code(
		input logic [fpp_pkg::BYTE_W-1:0] c
	);
		logic [fpp_pkg::PIECE_W:0] r;
		unique case (c)
			fpp_pkg::CH_P: r = {1'b1, 3'd0};
			fpp_pkg::CH_R: r = {1'b1, 3'd1};
			fpp_pkg::CH_N: r = {1'b1, 3'd2};
			fpp_pkg::CH_B: r = {1'b1, 3'd3};
			fpp_pkg::CH_Q: r = {1'b1, 3'd4};
			fpp_pkg::CH_K: r = {1'b1, 3'd5};
			default:       r = '0;
		endcase
		return r;
	endfunction

	// {known, bit index}
	function automatic logic [2:0] castle_bit(input logic [fpp_pkg::BYTE_W-1:0] c);
		logic [2:0] r;
		unique case (c)
			fpp_pkg::CH_UP_K: r = {1'b1, 2'd0};
			fpp_pkg::CH_UP_Q: r = {1'b1, 2'd1};
			fpp_pkg::CH_K:    r = {1'b1, 2'd2};
			fpp_pkg::CH_Q:    r = {1'b1, 2'd3};
			default:          r = '0;
		endcase
		return r;
	endfunction

	fpp_pkg::fpp_state_t             cur;
	logic                            is_dig;
	logic                            is_skip;
	logic                            bad;
	logic                            good;
	logic [fpp_pkg::MOVES_W-1:0]     acc_in;
	logic [fpp_pkg::MOVES_W-1:0]     acc_nxt;
	logic [fpp_pkg::DIGCNT_W-1:0]    dc_nxt;
	logic                            lz_nxt;
	logic                            dig_fault;
	logic [fpp_pkg::BYTE_W-1:0]      lc;
	logic [fpp_pkg::PIECE_W:0]       pc;
	logic [2:0]                      cb;
	logic [fpp_pkg::COUNT_W-1:0]     sq_n;
	logic [fpp_pkg::COUNT_W-1:0]     rf_n;
	logic [fpp_pkg::COUNT_W-1:0]     step_n;

	assign cur     = first_in ? fpp_pkg::STATE_RESET : state_cur;
	assign is_dig  = (byte_in >= fpp_pkg::CH_0) && (byte_in <= fpp_pkg::CH_9);
	assign is_skip = (byte_in >= fpp_pkg::CH_1) && (byte_in <= fpp_pkg::CH_8);
	assign acc_in  = (cur.phase == fpp_pkg::PH_FULL) ? cur.full_count : cur.half_count;
	assign lc      = ((byte_in >= fpp_pkg::CH_UP_A) && (byte_in <= fpp_pkg::CH_UP_Z)) ?
		byte_in + fpp_pkg::CASE_OFS : byte_in;
	assign pc      = piece_code(lc);
	assign cb      = castle_bit(byte_in);

	fpp_digit_acc u_digit (
		.acc             (acc_in),
		.digit           (byte_in[3:0]),
		.digit_count     (cur.digit_count),
		.lead_zero       (cur.lead_zero),
		.acc_nxt         (acc_nxt),
		.digit_count_nxt (dc_nxt),
		.lead_zero_nxt   (lz_nxt),
		.fault           (dig_fault)
	);

	always_comb begin
		state_nxt = cur;
		emit      = 1'b0;
		res       = '0;
		bad       = 1'b0;
		good      = 1'b0;
		step_n    = is_skip ? fpp_pkg::COUNT_W'(byte_in[3:0]) : fpp_pkg::COUNT_W'(1);
		sq_n      = cur.square_count + step_n;
		rf_n      = cur.rank_fill + step_n;

		if (!cur.finished) begin
			if (cur.phase == fpp_pkg::PH_FULL) begin
				if (is_dig) begin
					if (dig_fault) begin
						bad = 1'b1;
					end else begin
						state_nxt.full_count  = acc_nxt;
						state_nxt.digit_count = dc_nxt;
						state_nxt.lead_zero   = lz_nxt;
					end
				end else if (cur.digit_count == '0 || cur.full_count == '0) begin
					bad = 1'b1;
				end else begin
					good = 1'b1;
				end
			end else if (byte_in == fpp_pkg::CH_NUL) begin
				bad = 1'b1;
			end else begin
				unique case (cur.phase)
					fpp_pkg::PH_BOARD: begin
						if (byte_in == fpp_pkg::CH_SLASH) begin
							if (cur.rank_fill != fpp_pkg::RANK_COLUMNS) begin
								bad = 1'b1;
							end else begin
								state_nxt.rank_fill = '0;
							end
						end else if (!is_skip && !pc[fpp_pkg::PIECE_W]) begin
							bad = 1'b1;
						end else begin
							if (!is_skip) begin
								emit            = 1'b1;
								res.kind        = fpp_pkg::KIND_PIECE;
								res.square      = cur.square_count[fpp_pkg::SQ_W-1:0];
								res.piece_type  = pc[fpp_pkg::PIECE_W-1:0];
								res.piece_black = (byte_in >= fpp_pkg::CH_LO_A) &&
									(byte_in <= fpp_pkg::CH_LO_Z);
							end
							state_nxt.square_count = sq_n;
							state_nxt.rank_fill    = rf_n;
							if (sq_n >= fpp_pkg::BOARD_SQUARES) begin
								if (sq_n != fpp_pkg::BOARD_SQUARES ||
									rf_n != fpp_pkg::RANK_COLUMNS) begin
									bad = 1'b1;
								end else begin
									state_nxt.phase = fpp_pkg::PH_SP1;
								end
							end
						end
					end
					fpp_pkg::PH_SP1, fpp_pkg::PH_SP2, fpp_pkg::PH_SP3, fpp_pkg::PH_SP4: begin
						if (byte_in != fpp_pkg::CH_SPACE) begin
							bad = 1'b1;
						end else if (cur.phase == fpp_pkg::PH_SP1) begin
							state_nxt.phase = fpp_pkg::PH_SIDE;
						end else if (cur.phase == fpp_pkg::PH_SP2) begin
							state_nxt.phase = fpp_pkg::PH_CASTLE0;
						end else if (cur.phase == fpp_pkg::PH_SP3) begin
							state_nxt.phase = fpp_pkg::PH_EPFILE;
						end else begin
							state_nxt.phase = fpp_pkg::PH_HALF;
						end
					end
					fpp_pkg::PH_SIDE: begin
						if (byte_in == fpp_pkg::CH_W) begin
							state_nxt.black_to_move = 1'b0;
							state_nxt.phase         = fpp_pkg::PH_SP2;
						end else if (byte_in == fpp_pkg::CH_B) begin
							state_nxt.black_to_move = 1'b1;
							state_nxt.phase         = fpp_pkg::PH_SP2;
						end else begin
							bad = 1'b1;
						end
					end
					fpp_pkg::PH_CASTLE0: begin
						if (byte_in == fpp_pkg::CH_DASH) begin
							state_nxt.phase = fpp_pkg::PH_SP3;
						end else if (!cb[2]) begin
							bad = 1'b1;
						end else begin
							state_nxt.rights[cb[1:0]] = 1'b1;
							state_nxt.phase           = fpp_pkg::PH_CASTLE;
						end
					end
					fpp_pkg::PH_CASTLE: begin
						if (byte_in == fpp_pkg::CH_SPACE) begin
							state_nxt.phase = fpp_pkg::PH_EPFILE;
						end else if (!cb[2] || cur.rights[cb[1:0]]) begin
							// unknown letter or a repeated right
							bad = 1'b1;
						end else begin
							state_nxt.rights[cb[1:0]] = 1'b1;
						end
					end
					fpp_pkg::PH_EPFILE: begin
						if (byte_in == fpp_pkg::CH_DASH) begin
							state_nxt.phase = fpp_pkg::PH_SP4;
						end else if (byte_in < fpp_pkg::CH_LO_A ||
							byte_in > fpp_pkg::CH_LO_H) begin
							bad = 1'b1;
						end else begin
							state_nxt.ep_where = {3'd0, byte_in[2:0] - 3'd1};
							state_nxt.phase    = fpp_pkg::PH_EPRANK;
						end
					end
					fpp_pkg::PH_EPRANK: begin
						if (!is_skip) begin
							bad = 1'b1;
						end else begin
							// rank 8 is row 0
							state_nxt.ep_where = cur.ep_where +
								{~(byte_in[2:0] - 3'd1), 3'd0};
							state_nxt.ep_flag  = 1'b1;
							state_nxt.phase    = fpp_pkg::PH_SP4;
						end
					end
					fpp_pkg::PH_HALF: begin
						if (is_dig) begin
							if (dig_fault) begin
								bad = 1'b1;
							end else begin
								state_nxt.half_count  = acc_nxt;
								state_nxt.digit_count = dc_nxt;
								state_nxt.lead_zero   = lz_nxt;
							end
						end else if (byte_in != fpp_pkg::CH_SPACE || cur.digit_count == '0) begin
							bad = 1'b1;
						end else begin
							state_nxt.digit_count = '0;
							state_nxt.lead_zero   = 1'b0;
							state_nxt.phase       = fpp_pkg::PH_FULL;
						end
					end
					default: begin
						bad = 1'b1;
					end
				endcase
			end
		end

		if (bad || good) begin
			emit               = 1'b1;
			res                = '0;
			res.kind           = fpp_pkg::KIND_SUMMARY;
			res.status         = bad ? fpp_pkg::STATUS_BAD : fpp_pkg::STATUS_OK;
			if (good) begin
				res.active_black  = cur.black_to_move;
				res.castle_rights = cur.rights;
				res.ep_valid      = cur.ep_flag;
				res.ep_square     = cur.ep_where;
				res.halfmoves     = cur.half_count;
				res.fullmoves     = cur.full_count;
			end
			state_nxt.finished = 1'b1;
		end
	end

endmodule
